>>> rtl/lpht_pkg.sv
// shared types, codes and hash constants of the linear probe hash table
package lpht_pkg;

	localparam int KEY_W       = 64;
	localparam int VALUE_W     = 64;
	localparam int LEN_W       = 4;
	localparam int OP_W        = 2;
	localparam int STATUS_W    = 2;
	localparam int ENTRY_CNT_W = 6;
	localparam int BYTE_IDX_W  = 3;

	// fnv-1a 64: the prime is 2^40 + 0x1b3, so the multiply is a shift plus a narrow product
	localparam logic [KEY_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [8:0]       FNV_LOW   = 9'h1B3;
	localparam int               FNV_SHIFT = 40;

	typedef enum logic [OP_W-1:0] {
		OP_GET  = 2'd0,
		OP_SET  = 2'd1,
		OP_DEL  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_INSERTED = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PRD,
		S_PCHK,
		S_GRD,
		S_GCHK,
		S_GHASH,
		S_GFREE,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		H_IDLE,
		H_BYTE,
		H_MOD,
		H_FIX
	} hash_state_t;

	typedef struct packed {
		logic             used;
		logic [LEN_W-1:0] key_len;
		logic [KEY_W-1:0] key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic             start;
		logic [KEY_W-1:0] key;
		logic [LEN_W-1:0] len;
	} hash_req_t;

endpackage

>>> rtl/lpht_req_if.sv
// request channel: operation, key and value
interface lpht_req_if import lpht_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [KEY_W-1:0]   key;
	logic [LEN_W-1:0]   key_length;
	logic [VALUE_W-1:0] value;

	modport source (output valid, operation, key, key_length, value, input ready);
	modport sink   (input valid, operation, key, key_length, value, output ready);
endinterface

>>> rtl/lpht_rsp_if.sv
// response channel: status, value read and entry count
interface lpht_rsp_if import lpht_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [VALUE_W-1:0]     read_value;
	logic [ENTRY_CNT_W-1:0] entry_count;

	modport source (output valid, status, read_value, entry_count, input ready);
	modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

>>> rtl/lpht_ram.sv
// generic single write port, single read port ram with registered read
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> rtl/lpht_hash.sv
// iterative fnv-1a hash, one key byte a cycle, then reduction to a slot index
module lpht_hash import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hash_req_t                      req,
	output logic                           done,
	output logic [$clog2(TABLE_SLOTS)-1:0] slot
);
	localparam int  AW   = $clog2(TABLE_SLOTS);
	localparam bit  POW2 = (TABLE_SLOTS == (1 << AW));
	localparam int  MD_W = AW + 8;
	// reciprocal of the table size, scaled by 2^MD_W and rounded down
	localparam logic [MD_W-1:0] RECIP = MD_W'((64'd1 << MD_W) / 64'(TABLE_SLOTS));

	hash_state_t           hstate_q;
	logic [KEY_W-1:0]      h_q;
	logic [KEY_W-1:0]      key_q;
	logic [LEN_W-1:0]      len_q;
	logic [BYTE_IDX_W-1:0] byte_q;
	logic [AW-1:0]         rem_q;
	logic [MD_W-1:0]       quo_q;
	logic                  done_q;
	logic [AW-1:0]         slot_q;

	logic [KEY_W-1:0]      mix;
	logic [KEY_W+8:0]      prod;
	logic [KEY_W-1:0]      h_next;
	logic                  last_byte;
	logic [MD_W-1:0]       md_x;
	logic [2*MD_W-1:0]     md_prod;
	logic [MD_W-1:0]       quo_next;
	logic [MD_W-1:0]       qn;
	logic [MD_W-1:0]       diff;
	logic [MD_W-1:0]       rem_fix;

	// one fnv round: xor the byte, multiply by the prime as shift plus narrow product
	always_comb begin
		mix       = h_q ^ {{(KEY_W-8){1'b0}}, key_q[{byte_q, 3'b000} +: 8]};
		prod      = mix * FNV_LOW;
		h_next    = prod[KEY_W-1:0] + (mix << FNV_SHIFT);
		last_byte = ({1'b0, byte_q} + LEN_W'(1)) == len_q;
	end

	// remainder step over one hash byte: quotient estimate, then subtract and correct once
	always_comb begin
		md_x     = {rem_q, h_q[{byte_q, 3'b000} +: 8]};
		md_prod  = md_x * RECIP;
		quo_next = md_prod[2*MD_W-1:MD_W];
		qn       = quo_q * MD_W'(TABLE_SLOTS);
		diff     = md_x - qn;
		rem_fix  = (diff >= MD_W'(TABLE_SLOTS)) ? diff - MD_W'(TABLE_SLOTS) : diff;
	end

	// sequencer for byte rounds and the byte-wise remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hstate_q <= H_IDLE;
			h_q      <= '0;
			key_q    <= '0;
			len_q    <= '0;
			byte_q   <= '0;
			rem_q    <= '0;
			quo_q    <= '0;
			done_q   <= 1'b0;
			slot_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (hstate_q)
				H_IDLE: begin
					if (req.start) begin
						h_q      <= FNV_BASIS;
						key_q    <= req.key;
						len_q    <= req.len;
						byte_q   <= '0;
						hstate_q <= H_BYTE;
					end
				end
				H_BYTE: begin
					h_q <= h_next;
					if (last_byte) begin
						if (POW2) begin
							slot_q   <= h_next[AW-1:0];
							done_q   <= 1'b1;
							hstate_q <= H_IDLE;
						end else begin
							rem_q    <= '0;
							byte_q   <= BYTE_IDX_W'(KEY_W/8-1);
							hstate_q <= H_MOD;
						end
					end else begin
						byte_q <= byte_q + BYTE_IDX_W'(1);
					end
				end
				H_MOD: begin
					quo_q    <= quo_next;
					hstate_q <= H_FIX;
				end
				H_FIX: begin
					rem_q  <= rem_fix[AW-1:0];
					byte_q <= byte_q - BYTE_IDX_W'(1);
					if (byte_q == '0) begin
						slot_q   <= rem_fix[AW-1:0];
						done_q   <= 1'b1;
						hstate_q <= H_IDLE;
					end else begin
						hstate_q <= H_MOD;
					end
				end
				default: hstate_q <= H_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign slot = slot_q;
endmodule

>>> rtl/linear_probe_hash_table_unit.sv
// top level of the linear probe hash table: sequencer, slot memory and count
//
// channel | dir | transaction
// req     | in  | operation, key, key_length, value
// rsp     | out | status, read_value, entry_count
//
// steps: a hash works through the key bytes (then a byte-wise reduction when TABLE_SLOTS is
// not a power of two), each probed slot is read and then checked on the single read port, and
// each slot scanned by a delete's gap refill is read and hashed, and freed when an entry moves.
// reset: a clearing pass writes every slot empty, req is not ready meanwhile.
// stalls: one request at a time; the next is taken while the previous response waits in
// the output register, and a request finishes only once that register is free.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
	parameter int TABLE_SLOTS = 64,
	parameter int KEY_BYTES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	lpht_req_if.sink   req,
	lpht_rsp_if.source rsp
);
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int CW = AW + 1;

	state_t               state_q, state_d;
	logic [OP_W-1:0]      op_q, op_d;
	logic [KEY_W-1:0]     key_q, key_d;
	logic [LEN_W-1:0]     len_q, len_d;
	logic [VALUE_W-1:0]   val_q, val_d;
	logic [AW-1:0]        idx_q, idx_d;
	logic [CW-1:0]        n_q, n_d;
	logic [AW-1:0]        gap_q, gap_d;
	logic [AW-1:0]        cur_q, cur_d;
	entry_t               ent_q, ent_d;
	logic [AW-1:0]        count_q, count_d;
	logic [AW-1:0]        clr_q, clr_d;
	logic [STATUS_W-1:0]  res_status_q, res_status_d;
	logic [VALUE_W-1:0]   res_value_q, res_value_d;
	logic                 rsp_valid_q, rsp_valid_d;
	logic [STATUS_W-1:0]  rsp_status_q, rsp_status_d;
	logic [VALUE_W-1:0]   rsp_value_q, rsp_value_d;
	logic [ENTRY_CNT_W-1:0] rsp_count_q, rsp_count_d;

	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	entry_t               wr_data;
	logic [AW-1:0]        rd_addr;
	entry_t               rd_data;
	hash_req_t            hreq;
	logic                 h_done;
	logic [AW-1:0]        h_slot;

	logic [LEN_W-1:0]     in_len;
	logic [KEY_W-1:0]     in_key;
	logic [AW-1:0]        idx_next;
	logic [AW-1:0]        cur_next;
	logic                 match;
	logic                 move;

	lpht_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_SLOTS)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	lpht_hash #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (hreq),
		.done   (h_done),
		.slot   (h_slot)
	);

	// clamp the key length and clear unused key bytes
	always_comb begin
		in_len = req.key_length;
		if (in_len == '0) begin
			in_len = LEN_W'(1);
		end
		if (in_len > LEN_W'(KEY_BYTES)) begin
			in_len = LEN_W'(KEY_BYTES);
		end
		for (int i = 0; i < KEY_W/8; i++) begin
			in_key[8*i +: 8] = (LEN_W'(i) < in_len) ? req.key[8*i +: 8] : 8'h00;
		end
	end

	// wrap-around slot steps, key match and backward-shift move test
	always_comb begin
		idx_next = (idx_q == AW'(TABLE_SLOTS-1)) ? '0 : idx_q + AW'(1);
		cur_next = (cur_q == AW'(TABLE_SLOTS-1)) ? '0 : cur_q + AW'(1);
		match    = rd_data.used && (rd_data.key_len == len_q) && (rd_data.key == key_q);
		if (cur_q > gap_q) begin
			move = (h_slot <= gap_q) || (h_slot > cur_q);
		end else begin
			move = (h_slot <= gap_q) && (h_slot > cur_q);
		end
	end

	// sequencer: next state, memory and hash control
	always_comb begin
		state_d      = state_q;
		op_d         = op_q;
		key_d        = key_q;
		len_d        = len_q;
		val_d        = val_q;
		idx_d        = idx_q;
		n_d          = n_q;
		gap_d        = gap_q;
		cur_d        = cur_q;
		ent_d        = ent_q;
		count_d      = count_q;
		clr_d        = clr_q;
		res_status_d = res_status_q;
		res_value_d  = res_value_q;
		rsp_valid_d  = rsp_valid_q && !rsp.ready;
		rsp_status_d = rsp_status_q;
		rsp_value_d  = rsp_value_q;
		rsp_count_d  = rsp_count_q;
		wr_en        = 1'b0;
		wr_addr      = idx_q;
		wr_data      = '0;
		rd_addr      = idx_q;
		hreq.start   = 1'b0;
		hreq.key     = key_q;
		hreq.len     = len_q;
		req.ready    = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				clr_d   = clr_q + AW'(1);
				if (clr_q == AW'(TABLE_SLOTS-1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					op_d         = req.operation;
					key_d        = in_key;
					len_d        = in_len;
					val_d        = req.value;
					res_status_d = ST_NOTFOUND;
					res_value_d  = '0;
					if (op_t'(req.operation) == OP_NONE) begin
						state_d = S_RESP;
					end else begin
						hreq.start = 1'b1;
						hreq.key   = in_key;
						hreq.len   = in_len;
						state_d    = S_HASH;
					end
				end
			end
			S_HASH: begin
				if (h_done) begin
					idx_d   = h_slot;
					n_d     = '0;
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				state_d = S_PCHK;
			end
			S_PCHK: begin
				if (match) begin
					unique case (op_t'(op_q))
						OP_GET: begin
							res_status_d = ST_OK;
							res_value_d  = rd_data.value;
							state_d      = S_RESP;
						end
						OP_SET: begin
							wr_en        = 1'b1;
							wr_data      = rd_data;
							wr_data.value = val_q;
							res_status_d = ST_OK;
							state_d      = S_RESP;
						end
						OP_DEL: begin
							wr_en        = 1'b1;
							wr_data      = '0;
							gap_d        = idx_q;
							cur_d        = idx_next;
							n_d          = '0;
							if (count_q != '0) begin
								count_d = count_q - AW'(1);
							end
							res_status_d = ST_OK;
							state_d      = S_GRD;
						end
						default: state_d = S_RESP;
					endcase
				end else if (!rd_data.used || (n_q + CW'(1) == CW'(TABLE_SLOTS))) begin
					// probe ended on an empty slot or after a full lap
					if (op_t'(op_q) == OP_SET) begin
						if ((count_q >= AW'(TABLE_SLOTS/2)) || rd_data.used) begin
							res_status_d = ST_FULL;
						end else begin
							wr_en           = 1'b1;
							wr_data.used    = 1'b1;
							wr_data.key_len = len_q;
							wr_data.key     = key_q;
							wr_data.value   = val_q;
							count_d         = count_q + AW'(1);
							res_status_d    = ST_INSERTED;
						end
					end
					state_d = S_RESP;
				end else begin
					n_d     = n_q + CW'(1);
					idx_d   = idx_next;
					state_d = S_PRD;
				end
			end
			S_GRD: begin
				rd_addr = cur_q;
				state_d = S_GCHK;
			end
			S_GCHK: begin
				if (!rd_data.used) begin
					state_d = S_RESP;
				end else begin
					ent_d      = rd_data;
					hreq.start = 1'b1;
					hreq.key   = rd_data.key;
					hreq.len   = rd_data.key_len;
					state_d    = S_GHASH;
				end
			end
			S_GHASH: begin
				if (h_done) begin
					if (move) begin
						wr_en   = 1'b1;
						wr_addr = gap_q;
						wr_data = ent_q;
						state_d = S_GFREE;
					end else begin
						n_d   = n_q + CW'(1);
						cur_d = cur_next;
						state_d = (n_q + CW'(1) < CW'(TABLE_SLOTS-1)) ? S_GRD : S_RESP;
					end
				end
			end
			S_GFREE: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = '0;
				gap_d   = cur_q;
				n_d     = n_q + CW'(1);
				cur_d   = cur_next;
				state_d = (n_q + CW'(1) < CW'(TABLE_SLOTS-1)) ? S_GRD : S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d  = 1'b1;
					rsp_status_d = res_status_q;
					rsp_value_d  = res_value_q;
					rsp_count_d  = ENTRY_CNT_W'(count_q);
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			op_q         <= '0;
			key_q        <= '0;
			len_q        <= '0;
			val_q        <= '0;
			idx_q        <= '0;
			n_q          <= '0;
			gap_q        <= '0;
			cur_q        <= '0;
			ent_q        <= '0;
			count_q      <= '0;
			clr_q        <= '0;
			res_status_q <= '0;
			res_value_q  <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= '0;
			rsp_value_q  <= '0;
			rsp_count_q  <= '0;
		end else begin
			state_q      <= state_d;
			op_q         <= op_d;
			key_q        <= key_d;
			len_q        <= len_d;
			val_q        <= val_d;
			idx_q        <= idx_d;
			n_q          <= n_d;
			gap_q        <= gap_d;
			cur_q        <= cur_d;
			ent_q        <= ent_d;
			count_q      <= count_d;
			clr_q        <= clr_d;
			res_status_q <= res_status_d;
			res_value_q  <= res_value_d;
			rsp_valid_q  <= rsp_valid_d;
			rsp_status_q <= rsp_status_d;
			rsp_value_q  <= rsp_value_d;
			rsp_count_q  <= rsp_count_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.entry_count = rsp_count_q;
endmodule

>>> test/linear_probe_hash_table_unit_test.sv
// self-checking testbench of the linear probe hash table unit
module linear_probe_hash_table_unit_test;
	import lpht_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 64;
	localparam int MAX_KEY_LEN = 8;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam logic [63:0] HASH_MULT = 64'd1099511628211;

	typedef struct {
		status_t                status;
		logic [VALUE_W-1:0]     read_value;
		logic [ENTRY_CNT_W-1:0] entry_count;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpht_req_if req ();
	lpht_rsp_if rsp ();

	linear_probe_hash_table_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// shadow copy of the table
	logic               shadow_used [SLOTS];
	logic [KEY_W-1:0]   shadow_key [SLOTS];
	logic [LEN_W-1:0]   shadow_len [SLOTS];
	logic [VALUE_W-1:0] shadow_value [SLOTS];
	int                 shadow_count;

	answer_t            pending_answers [$];
	int                 fail_count  = 0;
	int                 cycle_count = 0;
	bit                 no_idle     = 1'b0;
	int                 stall_left  = 0;

	// key pool for the random traffic, stored in normal form
	logic [KEY_W-1:0]   pool_key [40];
	logic [LEN_W-1:0]   pool_len [40];

	always #10 clk = ~clk;

	// timeout guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("linear_probe_hash_table_unit verification failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic int fnv_home(logic [KEY_W-1:0] k, int len);
		logic [63:0] h;
		h = 64'hCBF2_9CE4_8422_2325;
		for (int i = 0; i < len; i++) begin
			h = h ^ {56'd0, k[8*i +: 8]};
			h = h * HASH_MULT;
		end
		return int'(h % SLOTS);
	endfunction

	// backward shift after a delete
	function automatic void close_gap(int gap);
		int  cur;
		int  h;
		bit  shift;
		cur = (gap + 1) % SLOTS;
		for (int n = 0; n + 1 < SLOTS && shadow_used[cur]; n++) begin
			h = fnv_home(shadow_key[cur], shadow_len[cur]);
			if (cur > gap)
				shift = (h <= gap) || (h > cur);
			else
				shift = (h <= gap) && (h > cur);
			if (shift) begin
				shadow_used[gap]  = 1'b1;
				shadow_key[gap]   = shadow_key[cur];
				shadow_len[gap]   = shadow_len[cur];
				shadow_value[gap] = shadow_value[cur];
				shadow_used[cur]  = 1'b0;
				gap = cur;
			end
			cur = (cur + 1) % SLOTS;
		end
	endfunction

	// work out the answer of one request and update the shadow table
	function automatic answer_t table_access(op_t op, logic [KEY_W-1:0] k,
			logic [LEN_W-1:0] raw_len, logic [VALUE_W-1:0] val);
		answer_t a;
		int      len;
		int      idx;
		int      at;
		bit      found;
		bit      empty;
		len = (raw_len == 0) ? 1 : (raw_len > MAX_KEY_LEN) ? MAX_KEY_LEN : int'(raw_len);
		if (len < 8)
			k = k & ((64'd1 << (8 * len)) - 64'd1);
		a.status     = ST_NOTFOUND;
		a.read_value = '0;
		if (op != OP_NONE) begin
			idx   = fnv_home(k, len);
			at    = idx;
			found = 1'b0;
			empty = 1'b0;
			for (int n = 0; n < SLOTS; n++) begin
				if (!shadow_used[idx]) begin
					empty = 1'b1;
					at    = idx;
					break;
				end
				if (shadow_len[idx] == len && shadow_key[idx] == k) begin
					found = 1'b1;
					at    = idx;
					break;
				end
				idx = (idx + 1) % SLOTS;
			end
			case (op)
				OP_GET: begin
					if (found) begin
						a.status     = ST_OK;
						a.read_value = shadow_value[at];
					end
				end
				OP_SET: begin
					if (found) begin
						shadow_value[at] = val;
						a.status = ST_OK;
					end else if (shadow_count >= SLOTS / 2 || !empty) begin
						a.status = ST_FULL;
					end else begin
						shadow_used[at]  = 1'b1;
						shadow_key[at]   = k;
						shadow_len[at]   = LEN_W'(len);
						shadow_value[at] = val;
						shadow_count++;
						a.status = ST_INSERTED;
					end
				end
				default: begin
					if (found) begin
						shadow_used[at] = 1'b0;
						close_gap(at);
						if (shadow_count > 0)
							shadow_count--;
						a.status = ST_OK;
					end
				end
			endcase
		end
		a.entry_count = ENTRY_CNT_W'(shadow_count);
		return a;
	endfunction

	// drive one request and record its answer once accepted
	task automatic send_request(op_t op, logic [KEY_W-1:0] k, logic [LEN_W-1:0] len,
			logic [VALUE_W-1:0] val);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid      <= 1'b1;
		req.operation  <= op;
		req.key        <= k;
		req.key_length <= len;
		req.value      <= val;
		do @(posedge clk); while (!req.ready);
		pending_answers.push_back(table_access(op, k, len, val));
	endtask

	// response side back-pressure
	always @(negedge clk) begin
		if (no_idle) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp.ready <= 1'b0;
			stall_left--;
		end else begin
			rsp.ready  <= 1'b1;
			stall_left = pick_gap();
		end
	end

	// compare every response transaction with the oldest answer
	always @(posedge clk) begin
		answer_t a;
		if (rsp.valid && rsp.ready) begin
			if (pending_answers.size() == 0) begin
				$error("response with nothing outstanding");
				fail_count++;
			end else begin
				a = pending_answers.pop_front();
				if (rsp.status !== a.status) begin
					$error("status: expected %0d, got %0d", a.status, rsp.status);
					fail_count++;
				end
				if (rsp.read_value !== a.read_value) begin
					$error("read_value: expected %h, got %h", a.read_value, rsp.read_value);
					fail_count++;
				end
				if (rsp.entry_count !== a.entry_count) begin
					$error("entry_count: expected %0d, got %0d", a.entry_count,
						rsp.entry_count);
					fail_count++;
				end
			end
		end
	end

	// edges of the fields and the odd cases
	task automatic test_directed();
		send_request(OP_GET, 64'h0, 4'd1, 64'h0);
		send_request(OP_SET, 64'h0, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_SET, 64'h0, 4'd2, 64'h1234);
		send_request(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
		send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, rand64());
		send_request(OP_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 64'h0);
		send_request(OP_GET, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 64'h0);
		send_request(OP_GET, 64'hAAAA_5555_AAAA_5500, 4'd1, 64'h0);
		send_request(OP_GET, 64'h0, 4'd2, 64'h0);
		send_request(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(OP_DEL, 64'h0, 4'd1, 64'h0);
		send_request(OP_DEL, 64'h0, 4'd1, 64'h0);
		send_request(OP_GET, 64'h0, 4'd1, 64'h0);
		send_request(OP_GET, 64'h0, 4'd2, 64'h0);
		send_request(OP_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0);
		send_request(OP_DEL, 64'h0, 4'd2, 64'h0);
	endtask

	// fill past the limit, update on a full table, then empty it again
	task automatic test_fill_and_drain();
		logic [KEY_W-1:0] k [36];
		int               order [36];
		int               j;
		int               t;
		for (int i = 0; i < 36; i++) begin
			k[i] = (rand64() & 64'hFFFF_FFFF_FFFF_FF00) | 64'(i);
			send_request(OP_SET, k[i], 4'd8, rand64());
			order[i] = i;
		end
		send_request(OP_SET, k[3], 4'd8, rand64());
		send_request(OP_GET, k[3], 4'd8, 64'h0);
		for (int i = 35; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < 36; i++) begin
			send_request(OP_DEL, k[order[i]], 4'd8, 64'h0);
			send_request(OP_GET, k[order[(i + 7) % 36]], 4'd8, 64'h0);
		end
	endtask

	// random mix over a pool of keys larger than the table limit
	task automatic test_random_traffic(int count);
		int               p;
		int               r;
		op_t              op;
		logic [KEY_W-1:0] k;
		logic [LEN_W-1:0] len;
		for (int i = 0; i < 40; i++) begin
			pool_len[i] = LEN_W'($urandom_range(1, MAX_KEY_LEN));
			pool_key[i] = rand64();
			if (pool_len[i] < 8)
				pool_key[i] = pool_key[i] & ((64'd1 << (8 * pool_len[i])) - 64'd1);
		end
		for (int i = 0; i < count; i++) begin
			if (i % 200 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			p   = $urandom_range(0, 39);
			k   = pool_key[p];
			len = pool_len[p];
			// garbage above the used bytes and aliased lengths
			if ($urandom_range(0, 1) && len < 8)
				k = k | (rand64() & ~((64'd1 << (8 * len)) - 64'd1));
			if (len == 8 && $urandom_range(0, 3) == 0)
				len = LEN_W'($urandom_range(9, 15));
			if (len == 1 && $urandom_range(0, 3) == 0)
				len = '0;
			r = $urandom_range(0, 99);
			if (r < 40)
				op = OP_SET;
			else if (r < 70)
				op = OP_GET;
			else if (r < 96)
				op = OP_DEL;
			else if (r < 98)
				op = OP_NONE;
			else begin
				op  = op_t'($urandom_range(0, 2));
				k   = rand64();
				len = LEN_W'($urandom_range(0, 15));
			end
			send_request(op, k, len, rand64());
		end
		no_idle = 1'b0;
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			shadow_used[i]  = 1'b0;
			shadow_key[i]   = '0;
			shadow_len[i]   = '0;
			shadow_value[i] = '0;
		end
		shadow_count   = 0;
		req.valid      = 1'b0;
		req.operation  = OP_GET;
		req.key        = '0;
		req.key_length = '0;
		req.value      = '0;
		rsp.ready      = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_fill_and_drain();
		test_random_traffic(1450);

		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (fail_count == 0)
			$display("linear_probe_hash_table_unit verification clean");
		else
			$display("linear_probe_hash_table_unit verification failed");
		$finish;
	end

endmodule

>>> linear_probe_hash_table_unit.f
rtl/lpht_pkg.sv
rtl/lpht_req_if.sv
rtl/lpht_rsp_if.sv
rtl/lpht_ram.sv
rtl/lpht_hash.sv
rtl/linear_probe_hash_table_unit.sv
test/linear_probe_hash_table_unit_test.sv
